// ===== rtl/mrd_pkg.sv =====
package mrd_pkg;

   localparam int MSG_W          = 32;
   localparam int OP_W           = 2;
   localparam int ST_W           = 2;
   localparam int CNT_W          = 5;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;
   localparam int SLOT_DEPTH_DEF = 16;

   localparam logic [CNT_W-1:0] CAPACITY_RST = CNT_W'(16);

   // request operation codes
   localparam logic [OP_W-1:0] OP_SEND = 2'd0;
   localparam logic [OP_W-1:0] OP_JAM  = 2'd1;
   localparam logic [OP_W-1:0] OP_RECV = 2'd2;

   // response status codes
   localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

   // register word index (paddr[2])
   localparam logic REG_CAPACITY = 1'b0;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [MSG_W-1:0] message_in;
   } req_type;

   typedef struct packed {
      logic [ST_W-1:0]  status;
      logic [MSG_W-1:0] message_out;
      logic [CNT_W-1:0] fill_level;
   } rsp_type;

endpackage

// ===== rtl/mrd_slot_ram.sv =====
module mrd_slot_ram #(
   parameter int DEPTH = mrd_pkg::SLOT_DEPTH_DEF,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [IDX_W-1:0]         wr_addr,
   input  logic [mrd_pkg::MSG_W-1:0] wr_data,
   input  logic                     rd_en,
   input  logic [IDX_W-1:0]         rd_addr,
   output logic [mrd_pkg::MSG_W-1:0] rd_data
);

   logic [mrd_pkg::MSG_W-1:0] mem [DEPTH];
   logic [mrd_pkg::MSG_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/message_ring_deque.sv =====
// message_ring_deque: a ring of 32-bit message slots used as a double-ended queue.
//
// Request channel (req_valid / req_stall / req_data): each request carries an op
// and a message word. Send appends at the tail, jam inserts ahead of the head so
// it is received first, receive removes the head word. A send or jam while full,
// or a receive while empty, is refused with a status and changes nothing.
// Response channel (rsp_valid / rsp_stall / rsp_data): exactly one response per
// request, in request order, with status, the received word (zero otherwise)
// and the fill level after the request.
// The response passes through the synchronous slot memory read and read stage,
// then through the output register.
// Throughput: one request per cycle while the response channel is not stalled;
// head and count update at the request edge and the memory has separate read
// and write ports, so back-to-back requests never collide on a slot.
// Stall: a stalled response holds the output register; the read stage then
// holds too and req_stall rises until the output drains.
// Reset: capacity returns to 16, the queue is empty, head is zero. No clearing
// pass: slots are only read after being written. Writing the capacity register
// (only while idle) re-creates the queue empty.
module message_ring_deque #(
   parameter int SLOT_DEPTH = mrd_pkg::SLOT_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  mrd_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output mrd_pkg::rsp_type                rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [mrd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [mrd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [mrd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   localparam int IDX_W   = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
   localparam int CNT_W   = mrd_pkg::CNT_W;
   localparam int CNT_MAX = (1 << CNT_W) - 1;
   localparam int CAP_MAX = (SLOT_DEPTH < CNT_MAX) ? SLOT_DEPTH : CNT_MAX;
   localparam logic [CNT_W-1:0] CAP_LIM = CNT_W'(CAP_MAX);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   // configuration
   logic [CNT_W-1:0] capacity_ff, capacity_in;
   logic             cfg_wr;
   logic [CNT_W-1:0] act_slots;

   // ring pointers
   logic [CNT_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // read stage
   logic                      s1_valid_ff, s1_valid_in;
   logic [mrd_pkg::ST_W-1:0]  s1_status_ff, s1_status_in;
   logic [CNT_W-1:0]          s1_fill_ff, s1_fill_in;
   logic                      s1_recv_ff, s1_recv_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   mrd_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic req_acc, s1_adv, out_free;

   logic [CNT_W:0]           tail_sum;
   logic [CNT_W-1:0]         tail_idx;
   logic [CNT_W-1:0]         head_dec, head_inc;
   logic                     q_full, q_empty;
   logic                     mem_wr;
   logic [IDX_W-1:0]         mem_wr_addr;
   logic [mrd_pkg::MSG_W-1:0] mem_rd_data;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite &&
                   (csr_paddr[2] == mrd_pkg::REG_CAPACITY);

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == mrd_pkg::REG_CAPACITY) begin
         csr_prdata = {{(mrd_pkg::CSR_DATA_W-CNT_W){1'b0}}, capacity_ff};
      end
   end

   assign capacity_in = cfg_wr ? csr_pwdata[CNT_W-1:0] : capacity_ff;

   // clamp capacity into 1..min(SLOT_DEPTH, CNT_MAX)
   always_comb begin
      act_slots = capacity_ff;
      if (capacity_ff == '0) begin
         act_slots = CNT_ONE;
      end else if (capacity_ff > CAP_LIM) begin
         act_slots = CAP_LIM;
      end
   end

   // ---------------- handshake ----------------
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_acc   = req_valid && !req_stall;

   // ---------------- ring arithmetic ----------------
   // head stays below act_slots and count at most act_slots, so one compare-subtract wraps the tail
   assign tail_sum = {1'b0, head_ff} + {1'b0, count_ff};
   always_comb begin
      tail_idx = tail_sum[CNT_W-1:0];
      if (tail_sum >= {1'b0, act_slots}) begin
         tail_idx = CNT_W'(tail_sum - {1'b0, act_slots});
      end
   end

   assign head_dec = (head_ff == '0) ? (act_slots - CNT_ONE) : (head_ff - CNT_ONE);
   assign head_inc = ((head_ff + CNT_ONE) == act_slots) ? '0 : (head_ff + CNT_ONE);
   assign q_full   = (count_ff >= act_slots);
   assign q_empty  = (count_ff == '0);

   // decode the request; update head and count at the accept edge
   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      mem_wr       = 1'b0;
      mem_wr_addr  = IDX_W'(tail_idx);
      s1_status_in = mrd_pkg::ST_DONE;
      s1_recv_in   = 1'b0;
      case (req_data.op)
         mrd_pkg::OP_SEND: begin
            if (q_full) begin
               s1_status_in = mrd_pkg::ST_FULL;
            end else begin
               mem_wr   = req_acc;
               count_in = count_ff + CNT_ONE;
            end
         end
         mrd_pkg::OP_JAM: begin
            if (q_full) begin
               s1_status_in = mrd_pkg::ST_FULL;
            end else begin
               mem_wr      = req_acc;
               mem_wr_addr = IDX_W'(head_dec);
               head_in     = head_dec;
               count_in    = count_ff + CNT_ONE;
            end
         end
         mrd_pkg::OP_RECV: begin
            if (q_empty) begin
               s1_status_in = mrd_pkg::ST_EMPTY;
            end else begin
               s1_recv_in = 1'b1;
               head_in    = head_inc;
               count_in   = count_ff - CNT_ONE;
            end
         end
         default: begin
            // unused code: no change, report done
         end
      endcase
      s1_fill_in  = count_in;
      s1_valid_in = req_acc || (s1_valid_ff && !s1_adv);
      if (!req_acc) begin
         head_in  = head_ff;
         count_in = count_ff;
      end
      // capacity write re-creates the queue
      if (cfg_wr) begin
         head_in  = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= mrd_pkg::CAPACITY_RST;
         head_ff     <= '0;
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         capacity_ff <= capacity_in;
         head_ff     <= head_in;
         count_ff    <= count_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // read-stage payload: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_status_ff <= s1_status_in;
         s1_fill_ff   <= s1_fill_in;
         s1_recv_ff   <= s1_recv_in;
      end
   end

   // ---------------- slot memory ----------------
   // the head slot is always the one read; only a receive uses the data
   mrd_slot_ram #(
      .DEPTH (SLOT_DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (mem_wr_addr),
      .wr_data (req_data.message_in),
      .rd_en   (req_acc),
      .rd_addr (IDX_W'(head_ff)),
      .rd_data (mem_rd_data)
   );

   // ---------------- output register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
      end
      if (s1_adv) begin
         rsp_data_in.status      = s1_status_ff;
         rsp_data_in.message_out = s1_recv_ff ? mem_rd_data : '0;
         rsp_data_in.fill_level  = s1_fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- assertions ----------------
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= act_slots)
      else $error("held count exceeds active capacity");

   a_head_in_range: assert property (@(posedge clock) disable iff (reset)
      head_ff < act_slots)
      else $error("head index outside active ring");

   a_refuse_no_change: assert property (@(posedge clock) disable iff (reset)
      (req_acc && !cfg_wr && (s1_status_in != mrd_pkg::ST_DONE))
      |=> ($stable(count_ff) && $stable(head_ff)))
      else $error("refused request changed the queue");

   a_msg_zero_unless_recv: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != mrd_pkg::ST_DONE)) |-> (rsp_data.message_out == '0))
      else $error("refused response carries a message");

endmodule

// ===== tb/message_ring_deque_check.sv =====
module message_ring_deque_check
   import mrd_pkg::*;
#(
   parameter int SLOT_DEPTH = SLOT_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  req_type                req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rsp_type                rsp_data,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   input  logic                   csr_pready,
   output int                     fail_count,
   output int                     pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // shadow copy of the queue
   logic [MSG_W-1:0] ring [SLOT_DEPTH];
   logic [CNT_W-1:0] head;
   logic [CNT_W-1:0] held;
   logic [CNT_W-1:0] cap_reg;

   rsp_type owed_rsps[$];
   int      miss_total = 0;

   // clamp the written capacity into 1..SLOT_DEPTH
   function automatic int unsigned live_slots();
      if (cap_reg == '0) return 1;
      if (cap_reg > SLOT_DEPTH) return SLOT_DEPTH;
      return cap_reg;
   endfunction

   // perform one request on the shadow queue and return its response
   function automatic rsp_type apply_request(req_type r);
      int unsigned cap;
      rsp_type     rsp;
      cap  = live_slots();
      rsp  = '0;
      head = CNT_W'(head % cap);
      case (r.op)
         OP_SEND, OP_JAM: begin
            if (held >= cap) begin
               rsp.status = ST_FULL;
            end else if (r.op == OP_SEND) begin
               ring[(head + held) % cap] = r.message_in;
               held = held + 1'b1;
            end else begin
               head = CNT_W'((head + cap - 1) % cap);
               ring[head] = r.message_in;
               held = held + 1'b1;
            end
         end
         OP_RECV: begin
            if (held == '0) begin
               rsp.status = ST_EMPTY;
            end else begin
               rsp.message_out = ring[head];
               head = CNT_W'((head + 1) % cap);
               held = held - 1'b1;
            end
         end
         default: ;
      endcase
      rsp.fill_level = held;
      return rsp;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         head    = '0;
         held    = '0;
         cap_reg = CAPACITY_RST;
         owed_rsps.delete();
      end else begin
         // a capacity write re-creates the queue empty
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[2] == REG_CAPACITY) begin
            cap_reg = csr_pwdata[CNT_W-1:0];
            head    = '0;
            held    = '0;
         end
         if (req_valid && !req_stall)
            owed_rsps.push_back(apply_request(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (owed_rsps.size() == 0) begin
               $error("response with nothing owed: status %0d message_out %08h fill %0d",
                      rsp_data.status, rsp_data.message_out, rsp_data.fill_level);
               miss_total++;
            end else begin
               want = owed_rsps.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  miss_total++;
               end
               if (rsp_data.message_out !== want.message_out) begin
                  $error("message_out: expected %08h, got %08h",
                         want.message_out, rsp_data.message_out);
                  miss_total++;
               end
               if (rsp_data.fill_level !== want.fill_level) begin
                  $error("fill_level: expected %0d, got %0d",
                         want.fill_level, rsp_data.fill_level);
                  miss_total++;
               end
            end
         end
      end
      fail_count <= miss_total;
      pending    <= owed_rsps.size();
   end

endmodule

// ===== tb/message_ring_deque_tb.sv =====
module message_ring_deque_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mrd_pkg::*;

   // op code the block must treat as a no-op
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   // cycles without any handshake before giving up
   localparam int STUCK_LIMIT = 3000;
   // capacity words used by the random phases; zero and above 16 test clamping
   localparam int PHASE_COUNT = 9;
   localparam logic [CNT_W-1:0] PHASE_CAP [PHASE_COUNT] =
      '{5'd16, 5'd0, 5'd31, 5'd17, 5'd1, 5'd2, 5'd7, 5'd11, 5'd16};
   localparam int PHASE_ITEMS = 150;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   req_type                req_data    = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   int fail_count;
   int pending;

   // sender burst state
   int burst_left = 0;
   bit gaps_on    = 1'b0;
   int stuck_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   message_ring_deque i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   message_ring_deque_check i_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   // Offer one request and hold it until the block takes it. Called at a
   // rising edge; returns at the edge where the request is accepted.
   task automatic offer(input logic [OP_W-1:0] op, input logic [MSG_W-1:0] msg);
      // drop valid for a random gap once the current burst runs out
      if (gaps_on && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_data  <= '{op: op, message_in: msg};
      do @(posedge clock); while (req_stall);
      if (burst_left > 0) burst_left--;
   endtask

   // Drop valid and wait until every response has come back. The first edge
   // lets the checker count the request taken at the edge we return from.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      // the block makes one response per request, so two pipeline stages
      // plus a little margin is enough
      repeat (4) @(posedge clock);
   endtask

   // Register write: setup, then access until pready.
   task automatic write_capacity(input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {REG_CAPACITY, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Mix of sends, jams and receives in stretches that lean toward filling,
   // draining or neither, so the ring wraps and hits full and empty often.
   task automatic run_traffic(input int count);
      int              taken;
      int              tilt;
      int              stretch;
      int              pick;
      int              recv_pct;
      logic [OP_W-1:0] op;
      logic [MSG_W-1:0] msg;
      taken = 0;
      while (taken < count) begin
         tilt    = $urandom_range(0, 2);
         stretch = $urandom_range(4, 40);
         recv_pct = (tilt == 0) ? 25 : (tilt == 1) ? 75 : 50;
         // some stretches run back to back without gaps
         gaps_on = ($urandom_range(0, 3) != 0);
         repeat (stretch) begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
               op = OP_UNUSED;
            else if ($urandom_range(0, 99) < recv_pct)
               op = OP_RECV;
            else
               op = $urandom_range(0, 1) ? OP_SEND : OP_JAM;
            case ($urandom_range(0, 9))
               0:       msg = '0;
               1:       msg = '1;
               default: msg = $urandom();
            endcase
            offer(op, msg);
            // no-ops do not count toward the phase size
            if (op != OP_UNUSED) taken++;
         end
      end
   endtask

   // Receiver: stall on a pattern of its own. Every few stretches hold off
   // for a long while so the block backs up and stalls its input.
   initial begin
      int k;
      int n;
      int mode;
      int beat;
      while (reset) @(posedge clock);
      for (k = 0; ; k++) begin
         if (k % 5 == 1) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(60, 120)) @(posedge clock);
         end else begin
            mode = $urandom_range(0, 3);
            n    = $urandom_range(20, 200);
            for (beat = 0; beat < n; beat++) begin
               case (mode)
                  0:       rsp_stall <= 1'b0;
                  1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                  2:       rsp_stall <= $urandom_range(0, 1);
                  default: rsp_stall <= (beat % 4 != 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // Watchdog: end the run if nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("FAIL message_ring_deque");
            $finish;
         end
      end
   end

   initial begin
      int p;
      logic [CSR_DATA_W-1:0] word;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset capacity of 16, empty refusal, field extremes, jam
      // ordering ahead of earlier sends, the unused op
      gaps_on = 1'b0;
      offer(OP_RECV, 32'hFFFF_FFFF);
      offer(OP_SEND, 32'h0000_0000);
      offer(OP_SEND, 32'hFFFF_FFFF);
      offer(OP_JAM, 32'hA5A5_A5A5);
      offer(OP_JAM, 32'h5A5A_5A5A);
      offer(OP_UNUSED, 32'h1357_9BDF);
      offer(OP_RECV, 32'h0000_0000);
      offer(OP_RECV, 32'h0000_0000);
      offer(OP_RECV, 32'h0000_0000);
      offer(OP_RECV, 32'h0000_0000);
      offer(OP_RECV, 32'h0000_0000);
      drain();

      // directed: single slot, so full refusals for both send and jam
      write_capacity(32'd1);
      offer(OP_SEND, 32'h1234_5678);
      offer(OP_SEND, 32'h8765_4321);
      offer(OP_JAM, 32'hCAFE_F00D);
      offer(OP_RECV, 32'h0000_0000);
      offer(OP_RECV, 32'h0000_0000);
      offer(OP_JAM, 32'h0F0F_F0F0);
      offer(OP_RECV, 32'h0000_0000);
      drain();

      // random phases over a range of capacities, extremes included
      for (p = 0; p < PHASE_COUNT; p++) begin
         word = CSR_DATA_W'(PHASE_CAP[p]);
         // junk in the unused upper bits on some writes
         if ($urandom_range(0, 1)) word = word | ($urandom() & 32'hFFFF_FFE0);
         write_capacity(word);
         run_traffic(PHASE_ITEMS);
         drain();
      end

      if (fail_count == 0 && pending == 0) begin
         $display("PASS message_ring_deque");
      end else begin
         $display("FAIL message_ring_deque");
      end
      $finish;
   end

endmodule
